// ===== design/rcc_pkg.sv =====
// Shared types and constants of the ring charge centroid block.
`default_nettype none

package rcc_pkg;

	localparam int X_W      = 16;
	localparam int Q_W      = 16;
	localparam int R2_W     = 32;
	localparam int INNER_W  = 31;
	localparam int STEP_W   = 28;
	localparam int WSUM_W   = 48;
	localparam int QSUM_W   = 32;
	localparam int PROD_W   = 33;
	localparam int RIDX_W   = 4;
	localparam int EMIT_W   = 4;
	localparam int DCNT_W   = 5;
	localparam int DQUO_W   = 16;
	localparam int CFG_IW   = 1;
	localparam int CFG_DW   = 31;
	localparam int S_DATA_W = 48;
	localparam int M_DATA_W = 40;

	localparam logic [INNER_W-1:0] INNER_RESET = 31'd16208676;
	localparam logic [STEP_W-1:0]  STEP_RESET  = 28'd2741453;

	localparam logic [CFG_IW-1:0] CFG_INNER_RADIUS_SQ = 1'b0;
	localparam logic [CFG_IW-1:0] CFG_AREA_STEP       = 1'b1;

	localparam logic [EMIT_W-1:0] EMIT_LAST = 4'd15;

	localparam logic signed [WSUM_W-1:0] WSUM_MAX = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [WSUM_W-1:0] WSUM_MIN = 48'sh8000_0000_0000;
	localparam logic [QSUM_W-1:0]        QSUM_MAX = 32'hFFFF_FFFF;
	localparam logic signed [X_W-1:0]    CENT_MAX = 16'sh7FFF;
	localparam logic signed [X_W-1:0]    CENT_MIN = 16'sh8000;
	localparam logic [DQUO_W-1:0]        CENT_NEG_LIM = 16'd32768;
	localparam logic [DCNT_W-1:0]        CENT_QBITS = 5'd16;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SQX,
		S_SQY,
		S_RANGE,
		S_RDIV,
		S_MULX,
		S_MULY,
		S_ACC,
		S_EMPTY,
		S_SCAN,
		S_LOAD,
		S_DIVX,
		S_DIVY,
		S_OUT
	} state_t;

	typedef struct packed {
		logic signed [WSUM_W-1:0] wx;
		logic signed [WSUM_W-1:0] wy;
		logic [QSUM_W-1:0]        qs;
	} ring_acc_t;

	typedef struct packed {
		logic              start;
		logic [WSUM_W-1:0] num;
		logic [QSUM_W-1:0] den;
		logic [DCNT_W-1:0] nbits;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic              ovf;
		logic [DQUO_W-1:0] quo;
	} div_rsp_t;

endpackage

`default_nettype wire

// ===== design/rcc_div.sv =====
// Restoring divider, one quotient bit per cycle, with an up-front overflow check.
`default_nettype none

module rcc_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire rcc_pkg::div_req_t req,
	output rcc_pkg::div_rsp_t      rsp
);

	localparam int RW = rcc_pkg::WSUM_W + 1;

	logic                         busy_q;
	logic                         chk_q;
	logic                         done_q;
	logic                         ovf_q;
	logic [rcc_pkg::DCNT_W-1:0]   cnt_q;
	logic [RW-1:0]                rem_q;
	logic [RW-1:0]                dsh_q;
	logic [rcc_pkg::DQUO_W-1:0]   quo_q;
	logic                         ge;
	logic [RW-1:0]                diff;

	assign ge   = rem_q >= dsh_q;
	assign diff = rem_q - dsh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			chk_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			chk_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= req.nbits;
		end else if (busy_q) begin
			if (chk_q) begin
				chk_q <= 1'b0;
				if (ge) begin
					// quotient would not fit in nbits: stop early
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == rcc_pkg::DCNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= {1'b0, req.num};
			dsh_q <= {(RW - rcc_pkg::QSUM_W)'(0), req.den} << req.nbits;
			quo_q <= '0;
			ovf_q <= 1'b0;
		end else if (busy_q) begin
			dsh_q <= dsh_q >> 1;
			if (chk_q) begin
				ovf_q <= ge;
			end else begin
				if (ge) begin
					rem_q <= diff;
				end
				quo_q <= {quo_q[rcc_pkg::DQUO_W-2:0], ge};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.ovf  = ovf_q;
	assign rsp.quo  = quo_q;

endmodule

`default_nettype wire

// ===== design/ring_charge_centroid_core.sv =====
// Hit binning into equal-area rings with per-ring charge-weighted centroids.
// A hit is not taken until the last one is through: two squarings on the shared multiplier,
// then an RW-bit ring quotient on the divider, RW = ceil(log2 RING_COUNT).
// On the last hit, each charged ring gets two 16-bit quotients on the shared divider and
// each uncharged ring is passed over in the scan; a track with no charged ring gives one empty result.
// Reset restores both registers and marks all ring stores empty at once.
`default_nettype none

module ring_charge_centroid_core #(
	parameter int RING_COUNT = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_axis_tvalid,
	output logic                                s_axis_tready,
	// hit_x, hit_y, hit_charge
	input  wire logic [rcc_pkg::S_DATA_W-1:0]   s_axis_tdata,
	input  wire logic                           s_axis_tlast,
	output logic                                m_axis_tvalid,
	input  wire logic                           m_axis_tready,
	// ring_index, centroid_x, centroid_y, zero pad
	output logic [rcc_pkg::M_DATA_W-1:0]        m_axis_tdata,
	// track_empty
	output logic                                m_axis_tuser,
	output logic                                m_axis_tlast,
	input  wire logic                           cfg_we,
	input  wire logic [rcc_pkg::CFG_IW-1:0]     cfg_index,
	input  wire logic [rcc_pkg::CFG_DW-1:0]     cfg_wdata
);

	localparam int RW = (RING_COUNT > 1) ? $clog2(RING_COUNT) : 1;

	rcc_pkg::state_t state_q, state_d;

	logic [rcc_pkg::INNER_W-1:0]       inner_q;
	logic [rcc_pkg::STEP_W-1:0]        step_q;

	logic signed [rcc_pkg::X_W-1:0]    hx_q, hy_q;
	logic [rcc_pkg::Q_W-1:0]           hq_q;
	logic                              last_q;
	logic [rcc_pkg::R2_W-2:0]          sq_q;
	logic [rcc_pkg::R2_W-1:0]          r2_q;
	logic [RW-1:0]                     ring_q;
	logic signed [rcc_pkg::PROD_W-1:0] px_q, py_q;

	logic signed [rcc_pkg::X_W:0]      mul_a, mul_b;
	logic signed [2*rcc_pkg::X_W+1:0]  mul_p;

	rcc_pkg::ring_acc_t                acc_mem_q [RING_COUNT];
	rcc_pkg::ring_acc_t                rd_q;
	logic                              rd_ok_q;
	logic [RING_COUNT-1:0]             valid_q;

	logic [RW-1:0]                     e_q;
	logic [rcc_pkg::EMIT_W-1:0]        n_q;
	logic signed [rcc_pkg::X_W-1:0]    cx_q, cy_q;

	logic                              ov_q;
	logic [rcc_pkg::RIDX_W-1:0]        o_ring_q;
	logic signed [rcc_pkg::X_W-1:0]    o_cx_q, o_cy_q;
	logic                              o_empty_q, o_last_q;

	rcc_pkg::div_req_t                 div_req;
	rcc_pkg::div_rsp_t                 div_rsp;

	logic                              rd_en;
	logic [RW-1:0]                     rd_addr;
	logic                              mem_we;
	logic                              out_load;
	logic                              emit_done;
	logic                              out_free;
	logic                              more_above;
	logic                              item_last;
	logic [rcc_pkg::R2_W-1:0]          inner_ext;
	rcc_pkg::ring_acc_t                acc_base, acc_new;
	logic [rcc_pkg::WSUM_W:0]          wx_sum, wy_sum;
	logic [rcc_pkg::QSUM_W:0]          qs_sum;
	logic [rcc_pkg::WSUM_W-1:0]        abs_wx, abs_wy;
	rcc_pkg::state_t                   emit_first;

	function automatic logic signed [rcc_pkg::X_W-1:0] clamp_cent(
		input logic [rcc_pkg::DQUO_W-1:0] mag,
		input logic                       ovf,
		input logic                       neg
	);
		if (neg) begin
			if (ovf || mag > rcc_pkg::CENT_NEG_LIM) begin
				return rcc_pkg::CENT_MIN;
			end
			return rcc_pkg::X_W'(~mag + 1'b1);
		end
		if (ovf || mag[rcc_pkg::DQUO_W-1]) begin
			return rcc_pkg::CENT_MAX;
		end
		return mag;
	endfunction

	rcc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign inner_ext  = {1'b0, inner_q};
	assign out_free   = !ov_q || m_axis_tready;
	assign emit_first = (valid_q == '0) ? rcc_pkg::S_EMPTY : rcc_pkg::S_SCAN;
	assign abs_wx     = rd_q.wx[rcc_pkg::WSUM_W-1] ? (~rd_q.wx + 1'b1) : rd_q.wx;
	assign abs_wy     = rd_q.wy[rcc_pkg::WSUM_W-1] ? (~rd_q.wy + 1'b1) : rd_q.wy;

	always_comb begin
		more_above = 1'b0;
		for (int i = 0; i < RING_COUNT; i++) begin
			if (valid_q[i] && (RW'(i) > e_q)) begin
				more_above = 1'b1;
			end
		end
	end

	assign item_last = (n_q == rcc_pkg::EMIT_LAST) || !more_above;

	// shared multiplier: squares first, then charge weighting
	always_comb begin
		unique case (state_q)
			rcc_pkg::S_SQX: begin
				mul_a = {hx_q[rcc_pkg::X_W-1], hx_q};
				mul_b = {hx_q[rcc_pkg::X_W-1], hx_q};
			end
			rcc_pkg::S_SQY: begin
				mul_a = {hy_q[rcc_pkg::X_W-1], hy_q};
				mul_b = {hy_q[rcc_pkg::X_W-1], hy_q};
			end
			rcc_pkg::S_MULX: begin
				mul_a = {hx_q[rcc_pkg::X_W-1], hx_q};
				mul_b = {1'b0, hq_q};
			end
			default: begin
				mul_a = {hy_q[rcc_pkg::X_W-1], hy_q};
				mul_b = {1'b0, hq_q};
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// saturating accumulate of one hit into its ring
	always_comb begin
		acc_base   = rd_ok_q ? rd_q : '0;
		wx_sum     = {acc_base.wx[rcc_pkg::WSUM_W-1], acc_base.wx}
		           + {{(rcc_pkg::WSUM_W + 1 - rcc_pkg::PROD_W){px_q[rcc_pkg::PROD_W-1]}}, px_q};
		wy_sum     = {acc_base.wy[rcc_pkg::WSUM_W-1], acc_base.wy}
		           + {{(rcc_pkg::WSUM_W + 1 - rcc_pkg::PROD_W){py_q[rcc_pkg::PROD_W-1]}}, py_q};
		qs_sum     = {1'b0, acc_base.qs} + {(rcc_pkg::QSUM_W + 1 - rcc_pkg::Q_W)'(0), hq_q};
		acc_new.wx = (wx_sum[rcc_pkg::WSUM_W] != wx_sum[rcc_pkg::WSUM_W-1])
		           ? (wx_sum[rcc_pkg::WSUM_W] ? rcc_pkg::WSUM_MIN : rcc_pkg::WSUM_MAX)
		           : wx_sum[rcc_pkg::WSUM_W-1:0];
		acc_new.wy = (wy_sum[rcc_pkg::WSUM_W] != wy_sum[rcc_pkg::WSUM_W-1])
		           ? (wy_sum[rcc_pkg::WSUM_W] ? rcc_pkg::WSUM_MIN : rcc_pkg::WSUM_MAX)
		           : wy_sum[rcc_pkg::WSUM_W-1:0];
		acc_new.qs = qs_sum[rcc_pkg::QSUM_W] ? rcc_pkg::QSUM_MAX : qs_sum[rcc_pkg::QSUM_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rcc_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		div_req       = '0;
		rd_en         = 1'b0;
		rd_addr       = ring_q;
		mem_we        = 1'b0;
		out_load      = 1'b0;
		emit_done     = 1'b0;
		unique case (state_q)
			rcc_pkg::S_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					state_d = rcc_pkg::S_SQX;
				end
			end
			rcc_pkg::S_SQX: begin
				state_d = rcc_pkg::S_SQY;
			end
			rcc_pkg::S_SQY: begin
				state_d = rcc_pkg::S_RANGE;
			end
			rcc_pkg::S_RANGE: begin
				if (r2_q < inner_ext) begin
					// drop the hit
					state_d = last_q ? emit_first : rcc_pkg::S_IDLE;
				end else begin
					div_req.start = 1'b1;
					div_req.num   = {(rcc_pkg::WSUM_W - rcc_pkg::R2_W)'(0), r2_q - inner_ext};
					div_req.den   = {(rcc_pkg::QSUM_W - rcc_pkg::STEP_W)'(0), step_q};
					div_req.nbits = rcc_pkg::DCNT_W'(RW);
					state_d       = rcc_pkg::S_RDIV;
				end
			end
			rcc_pkg::S_RDIV: begin
				if (div_rsp.done) begin
					state_d = rcc_pkg::S_MULX;
				end
			end
			rcc_pkg::S_MULX: begin
				rd_en   = 1'b1;
				state_d = rcc_pkg::S_MULY;
			end
			rcc_pkg::S_MULY: begin
				state_d = rcc_pkg::S_ACC;
			end
			rcc_pkg::S_ACC: begin
				mem_we  = 1'b1;
				state_d = last_q ? rcc_pkg::S_SCAN : rcc_pkg::S_IDLE;
			end
			rcc_pkg::S_EMPTY: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = rcc_pkg::S_IDLE;
				end
			end
			rcc_pkg::S_SCAN: begin
				rd_addr = e_q;
				if (valid_q[e_q]) begin
					rd_en   = 1'b1;
					state_d = rcc_pkg::S_LOAD;
				end
			end
			rcc_pkg::S_LOAD: begin
				div_req.start = 1'b1;
				div_req.num   = abs_wx;
				div_req.den   = rd_q.qs;
				div_req.nbits = rcc_pkg::CENT_QBITS;
				state_d       = rcc_pkg::S_DIVX;
			end
			rcc_pkg::S_DIVX: begin
				if (div_rsp.done) begin
					div_req.start = 1'b1;
					div_req.num   = abs_wy;
					div_req.den   = rd_q.qs;
					div_req.nbits = rcc_pkg::CENT_QBITS;
					state_d       = rcc_pkg::S_DIVY;
				end
			end
			rcc_pkg::S_DIVY: begin
				if (div_rsp.done) begin
					state_d = rcc_pkg::S_OUT;
				end
			end
			rcc_pkg::S_OUT: begin
				if (out_free) begin
					out_load = 1'b1;
					if (item_last) begin
						emit_done = 1'b1;
						state_d   = rcc_pkg::S_IDLE;
					end else begin
						state_d = rcc_pkg::S_SCAN;
					end
				end
			end
			default: begin
				state_d = rcc_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inner_q <= rcc_pkg::INNER_RESET;
			step_q  <= rcc_pkg::STEP_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rcc_pkg::CFG_INNER_RADIUS_SQ: inner_q <= cfg_wdata;
				rcc_pkg::CFG_AREA_STEP:       step_q  <= cfg_wdata[rcc_pkg::STEP_W-1:0];
			endcase
		end
	end

	// ring occupancy and emission counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			e_q     <= '0;
			n_q     <= '0;
		end else begin
			if (emit_done) begin
				valid_q <= '0;
				e_q     <= '0;
				n_q     <= '0;
			end else begin
				if (mem_we) begin
					valid_q[ring_q] <= 1'b1;
				end
				if (state_q == rcc_pkg::S_SCAN && !valid_q[e_q]) begin
					e_q <= e_q + 1'b1;
				end
				if (out_load && state_q == rcc_pkg::S_OUT) begin
					e_q <= e_q + 1'b1;
					n_q <= n_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (out_load) begin
			ov_q <= 1'b1;
		end else if (m_axis_tready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			acc_mem_q[ring_q] <= acc_new;
		end
		if (rd_en) begin
			rd_q    <= acc_mem_q[rd_addr];
			rd_ok_q <= valid_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == rcc_pkg::S_IDLE && s_axis_tvalid) begin
			hx_q   <= s_axis_tdata[rcc_pkg::X_W-1:0];
			hy_q   <= s_axis_tdata[2*rcc_pkg::X_W-1:rcc_pkg::X_W];
			hq_q   <= (s_axis_tdata[rcc_pkg::S_DATA_W-1:2*rcc_pkg::X_W] == '0)
			        ? rcc_pkg::Q_W'(1) : s_axis_tdata[rcc_pkg::S_DATA_W-1:2*rcc_pkg::X_W];
			last_q <= s_axis_tlast;
		end
		if (state_q == rcc_pkg::S_SQX) begin
			sq_q <= mul_p[rcc_pkg::R2_W-2:0];
		end
		if (state_q == rcc_pkg::S_SQY) begin
			r2_q <= {1'b0, sq_q} + {1'b0, mul_p[rcc_pkg::R2_W-2:0]};
		end
		if (state_q == rcc_pkg::S_RDIV && div_rsp.done) begin
			// past the outer edge: hold in the last ring
			if (div_rsp.ovf || div_rsp.quo >= rcc_pkg::DQUO_W'(RING_COUNT)) begin
				ring_q <= RW'(RING_COUNT - 1);
			end else begin
				ring_q <= div_rsp.quo[RW-1:0];
			end
		end
		if (state_q == rcc_pkg::S_MULX) begin
			px_q <= mul_p[rcc_pkg::PROD_W-1:0];
		end
		if (state_q == rcc_pkg::S_MULY) begin
			py_q <= mul_p[rcc_pkg::PROD_W-1:0];
		end
		if (state_q == rcc_pkg::S_DIVX && div_rsp.done) begin
			cx_q <= clamp_cent(div_rsp.quo, div_rsp.ovf, rd_q.wx[rcc_pkg::WSUM_W-1]);
		end
		if (state_q == rcc_pkg::S_DIVY && div_rsp.done) begin
			cy_q <= clamp_cent(div_rsp.quo, div_rsp.ovf, rd_q.wy[rcc_pkg::WSUM_W-1]);
		end
		if (out_load) begin
			if (state_q == rcc_pkg::S_EMPTY) begin
				o_ring_q  <= '0;
				o_cx_q    <= '0;
				o_cy_q    <= '0;
				o_empty_q <= 1'b1;
				o_last_q  <= 1'b1;
			end else begin
				o_ring_q  <= rcc_pkg::RIDX_W'(e_q);
				o_cx_q    <= cx_q;
				o_cy_q    <= cy_q;
				o_empty_q <= 1'b0;
				o_last_q  <= item_last;
			end
		end
	end

	assign m_axis_tvalid = ov_q;
	assign m_axis_tdata  = {(rcc_pkg::M_DATA_W - rcc_pkg::RIDX_W - 2*rcc_pkg::X_W)'(0),
	                        o_cy_q, o_cx_q, o_ring_q};
	assign m_axis_tuser  = o_empty_q;
	assign m_axis_tlast  = o_last_q;

endmodule

`default_nettype wire

// ===== bench/ring_charge_centroid_core_tb.sv =====
// Self-checking bench for the ring charge centroid core: random tracks against a ring predictor.
`timescale 1ns / 100ps

module ring_charge_centroid_core_tb;

	localparam int RINGS       = 16;
	localparam int SETTLE_CYC  = 60;

	typedef struct packed {
		logic signed [rcc_pkg::X_W-1:0] x;
		logic signed [rcc_pkg::X_W-1:0] y;
		logic [rcc_pkg::Q_W-1:0]        q;
		logic                           last;
	} hit_t;

	typedef struct packed {
		logic [rcc_pkg::RIDX_W-1:0]     ring;
		logic signed [rcc_pkg::X_W-1:0] cx;
		logic signed [rcc_pkg::X_W-1:0] cy;
		logic                           empty;
		logic                           last;
	} centroid_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [rcc_pkg::S_DATA_W-1:0] s_axis_tdata = '0;
	logic s_axis_tlast = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [rcc_pkg::M_DATA_W-1:0] m_axis_tdata;
	logic m_axis_tuser;
	logic m_axis_tlast;
	logic cfg_we = 1'b0;
	logic [rcc_pkg::CFG_IW-1:0] cfg_index = '0;
	logic [rcc_pkg::CFG_DW-1:0] cfg_wdata = '0;

	// predictor copy of the registers and ring stores
	logic [rcc_pkg::INNER_W-1:0] inner_sq = rcc_pkg::INNER_RESET;
	logic [rcc_pkg::STEP_W-1:0]  step_sq  = rcc_pkg::STEP_RESET;
	longint ring_wx [RINGS];
	longint ring_wy [RINGS];
	longint ring_q  [RINGS];

	hit_t      hit_queue [$];
	centroid_t centroid_queue [$];
	hit_t      cur_hit;
	centroid_t got, want;
	bit        no_idle = 1'b0;
	int        fail_count = 0;

	ring_charge_centroid_core #(
		.RING_COUNT(RINGS)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic longint sat_wsum(input longint v);
		if (v > longint'(rcc_pkg::WSUM_MAX))
			return longint'(rcc_pkg::WSUM_MAX);
		if (v < longint'(rcc_pkg::WSUM_MIN))
			return longint'(rcc_pkg::WSUM_MIN);
		return v;
	endfunction

	function automatic logic signed [rcc_pkg::X_W-1:0] clamp_cent(input longint v);
		if (v > 32767)
			return rcc_pkg::CENT_MAX;
		if (v < -32768)
			return rcc_pkg::CENT_MIN;
		return v[rcc_pkg::X_W-1:0];
	endfunction

	// Bin one hit into its ring; on the last hit of a track queue the centroids and clear.
	function automatic void bin_hit(input hit_t h);
		longint sx, sy, qv, r2, k;
		int ring, n;
		centroid_t c;
		sx = h.x;
		sy = h.y;
		qv = (h.q == '0) ? 1 : h.q;
		r2 = sx * sx + sy * sy;
		ring = -1;
		if (r2 >= longint'(inner_sq)) begin
			if (step_sq == '0) begin
				ring = RINGS - 1;
			end else begin
				k = (r2 - longint'(inner_sq)) / longint'(step_sq);
				ring = (k >= RINGS) ? RINGS - 1 : int'(k);
			end
		end
		if (ring >= 0) begin
			ring_wx[ring] = sat_wsum(ring_wx[ring] + sx * qv);
			ring_wy[ring] = sat_wsum(ring_wy[ring] + sy * qv);
			ring_q[ring] = ring_q[ring] + qv;
			if (ring_q[ring] > longint'(rcc_pkg::QSUM_MAX))
				ring_q[ring] = longint'(rcc_pkg::QSUM_MAX);
		end
		if (!h.last)
			return;
		n = 0;
		for (int i = 0; i < RINGS; i++) begin
			if (ring_q[i] != 0 && n < 16) begin
				c.ring = rcc_pkg::RIDX_W'(i);
				c.cx = clamp_cent(ring_wx[i] / ring_q[i]);
				c.cy = clamp_cent(ring_wy[i] / ring_q[i]);
				c.empty = 1'b0;
				c.last = 1'b0;
				centroid_queue.insert(centroid_queue.size(), c);
				n++;
			end
		end
		if (n == 0) begin
			c = '0;
			c.empty = 1'b1;
			c.last = 1'b1;
			centroid_queue.insert(centroid_queue.size(), c);
		end else begin
			centroid_queue[centroid_queue.size() - 1].last = 1'b1;
		end
		for (int i = 0; i < RINGS; i++) begin
			ring_wx[i] = 0;
			ring_wy[i] = 0;
			ring_q[i] = 0;
		end
	endfunction

	// Place a hit at squared radius r2 under a random angle.
	function automatic hit_t hit_at(input longint r2, input logic [rcc_pkg::Q_W-1:0] q,
		input logic last);
		real rad, ang;
		longint vx, vy;
		hit_t h;
		rad = $sqrt(real'(r2));
		ang = 6.283185307 * $urandom_range(0, 9999) / 10000.0;
		vx = $rtoi(rad * $cos(ang));
		vy = $rtoi(rad * $sin(ang));
		h.x = (vx > 32767) ? rcc_pkg::CENT_MAX
		    : (vx < -32768) ? rcc_pkg::CENT_MIN : vx[rcc_pkg::X_W-1:0];
		h.y = (vy > 32767) ? rcc_pkg::CENT_MAX
		    : (vy < -32768) ? rcc_pkg::CENT_MIN : vy[rcc_pkg::X_W-1:0];
		h.q = q;
		h.last = last;
		return h;
	endfunction

	function automatic hit_t random_hit(input logic last);
		longint lo, hi, tgt;
		logic [rcc_pkg::Q_W-1:0] q;
		hit_t h;
		case ($urandom_range(9))
			0: q = '0;
			1: q = '1;
			default: q = rcc_pkg::Q_W'($urandom_range(65535));
		endcase
		if ($urandom_range(99) < 25) begin
			h.x = rcc_pkg::X_W'($urandom);
			h.y = rcc_pkg::X_W'($urandom);
			h.q = q;
			h.last = last;
			return h;
		end
		// aim mostly at the ring span, a little inside and past it
		lo = longint'(inner_sq) - longint'(step_sq);
		if (lo < 0)
			lo = 0;
		hi = longint'(inner_sq) + 17 * longint'(step_sq);
		if (hi > 64'sd2147483648)
			hi = 64'sd2147483648;
		tgt = lo + longint'($urandom % (hi - lo + 1));
		return hit_at(tgt, q, last);
	endfunction

	task automatic push_hit(input int x, input int y, input int q, input logic last);
		hit_t h;
		h.x = rcc_pkg::X_W'(x);
		h.y = rcc_pkg::X_W'(y);
		h.q = rcc_pkg::Q_W'(q);
		h.last = last;
		hit_queue.insert(hit_queue.size(), h);
	endtask

	task automatic add_tracks(input int budget);
		int len;
		while (budget > 0) begin
			len = $urandom_range(1, 12);
			if (len > budget)
				len = budget;
			for (int i = 0; i < len; i++)
				hit_queue.insert(hit_queue.size(), random_hit(i == len - 1));
			budget -= len;
		end
	endtask

	task automatic wait_drained();
		while (hit_queue.size() != 0 || s_axis_tvalid || centroid_queue.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic set_rings(input logic [rcc_pkg::INNER_W-1:0] inner,
		input logic [rcc_pkg::STEP_W-1:0] step);
		wait_drained();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= rcc_pkg::CFG_INNER_RADIUS_SQ;
		cfg_wdata <= inner;
		@(posedge clk);
		cfg_index <= rcc_pkg::CFG_AREA_STEP;
		cfg_wdata <= rcc_pkg::CFG_DW'(step);
		@(posedge clk);
		cfg_we <= 1'b0;
		inner_sq = inner;
		step_sq = step;
	endtask

	// hit driver: hold an item until accepted, idle now and then between items
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				bin_hit(cur_hit);
			if (!s_axis_tvalid || s_axis_tready) begin
				if (hit_queue.size() != 0 && (no_idle || $urandom_range(99) >= 8)) begin
					cur_hit = hit_queue.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {cur_hit.q, cur_hit.y, cur_hit.x};
					s_axis_tlast <= cur_hit.last;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// centroid monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.ring = m_axis_tdata[rcc_pkg::RIDX_W-1:0];
				got.cx = m_axis_tdata[rcc_pkg::RIDX_W +: rcc_pkg::X_W];
				got.cy = m_axis_tdata[rcc_pkg::RIDX_W + rcc_pkg::X_W +: rcc_pkg::X_W];
				got.empty = m_axis_tuser;
				got.last = m_axis_tlast;
				if (centroid_queue.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected centroid: ring %0d x %0d y %0d empty %0b last %0b",
							got.ring, got.cx, got.cy, got.empty, got.last);
				end else begin
					want = centroid_queue.pop_front();
					if (got.ring !== want.ring || got.cx !== want.cx || got.cy !== want.cy ||
						got.empty !== want.empty || got.last !== want.last) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("centroid mismatch: exp ring %0d x %0d y %0d empty %0b last %0b",
								want.ring, want.cx, want.cy, want.empty, want.last);
							$display("                   got ring %0d x %0d y %0d empty %0b last %0b",
								got.ring, got.cx, got.cy, got.empty, got.last);
						end
					end
				end
			end
			m_axis_tready <= no_idle || ($urandom_range(99) >= 8);
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset edges: ring 0 on its inner edge, corners past the outer edge, zero charge
		push_hit(4026, 0, 0, 1'b0);
		push_hit(0, -4026, 3, 1'b0);
		push_hit(-32768, -32768, 65535, 1'b0);
		push_hit(32767, 32767, 65535, 1'b1);
		// every hit inside the inner edge: empty track
		push_hit(0, 0, 7, 1'b1);
		// one hit in the middle of every ring
		for (int i = 0; i < RINGS; i++)
			hit_queue.insert(hit_queue.size(),
				hit_at(longint'(inner_sq) + longint'(i) * step_sq + step_sq / 2,
				rcc_pkg::Q_W'($urandom), i == RINGS - 1));

		// exact squared edges: 25 starts ring 0, 169 starts ring 1
		set_rings(31'd25, 28'd144);
		push_hit(12, 5, 1, 1'b0);
		push_hit(4, 2, 9, 1'b0);
		push_hit(3, 4, 2, 1'b1);

		// zero step: everything outside the inner edge lands in the last ring
		set_rings(31'd100, 28'd0);
		push_hit(0, 0, 4, 1'b0);
		push_hit(10, 0, 0, 1'b0);
		push_hit(-300, 200, 65535, 1'b1);

		set_rings(rcc_pkg::INNER_RESET, rcc_pkg::STEP_RESET);
		add_tracks(60);

		set_rings('0, rcc_pkg::STEP_W'($urandom_range(1, 4000000)));
		no_idle = 1'b1;
		add_tracks(45);
		wait_drained();
		no_idle = 1'b0;

		set_rings(rcc_pkg::INNER_W'($urandom_range(0, 200000000)),
			rcc_pkg::STEP_W'($urandom_range(1, 60000000)));
		add_tracks(60);

		set_rings('1, '1);
		add_tracks(20);

		wait_drained();
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#3_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== ring_charge_centroid_core.f =====
design/rcc_pkg.sv
design/rcc_div.sv
design/ring_charge_centroid_core.sv
bench/ring_charge_centroid_core_tb.sv
